/* src/mqtt_inbound_packet_parser_core_macros.svh */
// Assertion macros for the inbound MQTT packet parser.
// Depends on nothing; the including module supplies i_clk and i_rst_n.
`ifndef MQTT_INBOUND_PACKET_PARSER_CORE_MACROS_SVH
`define MQTT_INBOUND_PACKET_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked only while out of reset.
`define MQIP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MQIP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define MQIP_ASSERT(lbl, prop, msg)
`define MQIP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

/* src/mqip_pkg.sv */
// Types and codes shared by the inbound MQTT packet parser modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mqip_pkg;

    localparam int KA_W  = 18;
    localparam int LEN_W = 28;

    // Parser phases; the unused code behaves as the header phase.
    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_LENGTH = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [KA_W-1:0] KEEPALIVE_RESET = 18'd30000;

    // Control packet types, upper nibble of the fixed header.
    localparam logic [3:0] TY_PUBLISH  = 4'h3;
    localparam logic [3:0] TY_PUBACK   = 4'h4;
    localparam logic [3:0] TY_PUBREC   = 4'h5;
    localparam logic [3:0] TY_PUBCOMP  = 4'h7;
    localparam logic [3:0] TY_SUBACK   = 4'h9;
    localparam logic [3:0] TY_UNSUBACK = 4'hB;
    localparam logic [3:0] TY_PINGREQ  = 4'hC;
    localparam logic [3:0] TY_PINGRESP = 4'hD;

    localparam logic [3:0] EV_PUBLISH   = 4'd0;
    localparam logic [3:0] EV_PUBACK    = 4'd1;
    localparam logic [3:0] EV_PUBREC    = 4'd2;
    localparam logic [3:0] EV_PUBCOMP   = 4'd3;
    localparam logic [3:0] EV_PINGREQ   = 4'd4;
    localparam logic [3:0] EV_PINGRESP  = 4'd5;
    localparam logic [3:0] EV_SUBACK    = 4'd6;
    localparam logic [3:0] EV_UNSUBACK  = 4'd7;
    localparam logic [3:0] EV_OTHER     = 4'd8;
    localparam logic [3:0] EV_DROPPED   = 4'd9;
    localparam logic [3:0] EV_KEEPALIVE = 4'd10;

    localparam logic [1:0] RP_NONE     = 2'd0;
    localparam logic [1:0] RP_PINGRESP = 2'd1;
    localparam logic [1:0] RP_PUBREL   = 2'd2;
    localparam logic [1:0] RP_PINGREQ  = 2'd3;

    typedef struct packed {
        logic [3:0]       event_res;
        logic [7:0]       header_byte;
        logic [15:0]      message_id;
        logic [15:0]      topic_length;
        logic [LEN_W-1:0] payload_length;
        logic [1:0]       reply;
    } t_result;

endpackage

`default_nettype wire

/* src/mqtt_inbound_packet_parser_core.sv */
// Top level of the inbound MQTT packet parser; uses mqip_parser, mqip_out_queue,
// mqip_pkg and the assertion macro header.
//
// Input channel (i_in_valid / o_in_ready) carries one transaction per received
// byte (i_mode = 0, i_rx_byte) or per millisecond tick (i_mode = 1). Each input
// transaction is processed in the cycle it is accepted, so the block takes one
// item per clock while o_in_ready is high. The item that ends a packet, or a
// tick past the keepalive, pushes one result into the queue for the output
// channel (o_out_valid / i_out_ready). Results sit in a two-entry queue: input
// stays ready while one result waits, and drops only when both entries are held
// by a stalled receiver. With the receiver always ready the sustained rate is
// one item per cycle. The keepalive register must be written through
// i_cfg_wr_en / i_cfg_wr_data only while the block is idle, which the block
// does not enforce. Reset is synchronous and active low; it empties the queue,
// returns the parser to the header phase and sets the keepalive to 30000 ms.
`timescale 1ns / 1ps
`default_nettype none
`include "mqtt_inbound_packet_parser_core_macros.svh"

module mqtt_inbound_packet_parser_core #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_wr_en,
    input  wire  [17:0]  i_cfg_wr_data,
    input  wire          i_in_valid,
    output logic         o_in_ready,
    input  wire          i_mode,
    input  wire  [7:0]   i_rx_byte,
    output logic         o_out_valid,
    input  wire          i_out_ready,
    output logic [3:0]   o_event_res,
    output logic [7:0]   o_header_byte,
    output logic [15:0]  o_message_id,
    output logic [15:0]  o_topic_length,
    output logic [27:0]  o_payload_length,
    output logic [1:0]   o_reply
);
    import mqip_pkg::*;

    logic    accept;
    logic    push;
    logic    full;
    t_result parsed;
    t_result head;

    assign o_in_ready = !full;
    assign accept     = i_in_valid && o_in_ready;

    mqip_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_accept     (accept),
        .i_mode       (i_mode),
        .i_rx_byte    (i_rx_byte),
        .o_push       (push),
        .o_result     (parsed)
    );

    mqip_out_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (parsed),
        .o_full (full),
        .o_valid(o_out_valid),
        .i_ready(i_out_ready),
        .o_data (head)
    );

    assign o_event_res      = head.event_res;
    assign o_header_byte    = head.header_byte;
    assign o_message_id     = head.message_id;
    assign o_topic_length   = head.topic_length;
    assign o_payload_length = head.payload_length;
    assign o_reply          = head.reply;

    `MQIP_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !o_out_valid && o_in_ready, "reset must empty the result queue")
    `MQIP_ASSERT(a_keepalive_reply, (o_out_valid && o_event_res == EV_KEEPALIVE) |-> (o_reply == RP_PINGREQ && o_header_byte == 8'd0), "keepalive result must request a ping")
    `MQIP_ASSERT(a_dropped_clean, (o_out_valid && o_event_res == EV_DROPPED) |-> (o_reply == RP_NONE && o_message_id == 16'd0 && o_payload_length == 28'd0), "dropped packet must carry no reply or id")
    `MQIP_ASSERT(a_stall_keeps_ready, (o_out_valid && !i_out_ready && $past(!o_out_valid)) |-> o_in_ready, "one waiting result must not block input")

endmodule

`default_nettype wire

/* src/mqip_parser.sv */
// Packet state machine and keepalive timer; one byte or tick per accepted cycle.
// Depends on mqip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mqip_parser #(
    parameter int MAX_PACKET_BYTES = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wr_en,
    input  wire  [17:0]              i_cfg_wr_data,
    input  wire                      i_accept,
    input  wire                      i_mode,
    input  wire  [7:0]               i_rx_byte,
    output logic                     o_push,
    output mqip_pkg::t_result        o_result
);
    import mqip_pkg::*;

    localparam int SC_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [SC_W-1:0] SC_MAX = SC_W'(MAX_PACKET_BYTES);

    logic [KA_W-1:0]  r_keepalive;
    logic [1:0]       r_phase,       n_phase;
    logic [7:0]       r_held_header, n_held_header;
    logic [LEN_W-1:0] r_total,       n_total;
    logic [2:0]       r_digits,      n_digits;
    logic [LEN_W-1:0] r_body_left,   n_body_left;
    logic [SC_W-1:0]  r_stored,      n_stored;
    logic [15:0]      r_fbw,         n_fbw;
    logic             r_overrun,     n_overrun;
    logic [KA_W-1:0]  r_idle,        n_idle;

    logic [KA_W:0]    idle_inc;
    logic [1:0]       digit_idx;
    logic [LEN_W-1:0] digit_val;
    logic [LEN_W-1:0] body_pos;
    logic [LEN_W:0]   tl_plus2;
    logic             finish;
    t_result          res;

    always_comb begin
        n_phase       = r_phase;
        n_held_header = r_held_header;
        n_total       = r_total;
        n_digits      = r_digits;
        n_body_left   = r_body_left;
        n_stored      = r_stored;
        n_fbw         = r_fbw;
        n_overrun     = r_overrun;
        n_idle        = r_idle;
        finish        = 1'b0;
        o_push        = 1'b0;
        res           = '0;

        idle_inc  = {1'b0, r_idle} + 19'd1;
        digit_idx = r_digits[1:0];
        digit_val = {21'd0, i_rx_byte[6:0]} << (7 * digit_idx);
        body_pos  = r_total - r_body_left;
        tl_plus2  = '0;

        if (i_mode) begin
            if (idle_inc > {1'b0, r_keepalive}) begin
                n_idle          = '0;
                o_push          = 1'b1;
                res.event_res   = EV_KEEPALIVE;
                res.reply       = RP_PINGREQ;
            end else begin
                n_idle = idle_inc[KA_W-1:0];
            end
        end else begin
            case (r_phase)
                PH_LENGTH: begin
                    n_total  = r_total + digit_val;
                    n_digits = {1'b0, digit_idx} + 3'd1;
                    if (r_stored < SC_MAX) begin
                        n_stored = r_stored + 1'b1;
                    end else begin
                        n_overrun = 1'b1;
                    end
                    // The fourth digit closes the field regardless of its top bit.
                    if (!(i_rx_byte[7] && digit_idx != 2'd3)) begin
                        if (n_total == '0) begin
                            finish = 1'b1;
                        end else begin
                            n_body_left = n_total;
                            n_phase     = PH_BODY;
                        end
                    end
                end
                PH_BODY: begin
                    if (body_pos == '0) begin
                        n_fbw = {i_rx_byte, 8'h00};
                    end else if (body_pos == 28'd1) begin
                        n_fbw = {r_fbw[15:8], i_rx_byte};
                    end
                    if (r_stored < SC_MAX) begin
                        n_stored = r_stored + 1'b1;
                    end else begin
                        n_overrun = 1'b1;
                    end
                    n_body_left = r_body_left - 1'b1;
                    if (n_body_left == '0) begin
                        finish = 1'b1;
                    end
                end
                default: begin
                    n_held_header = i_rx_byte;
                    n_total       = '0;
                    n_digits      = '0;
                    n_body_left   = '0;
                    n_stored      = SC_W'(1);
                    n_fbw         = '0;
                    n_overrun     = 1'b0;
                    n_phase       = PH_LENGTH;
                end
            endcase

            if (finish) begin
                n_phase         = PH_HEADER;
                o_push          = 1'b1;
                res.header_byte = r_held_header;
                if (n_overrun) begin
                    res.event_res = EV_DROPPED;
                end else begin
                    n_idle         = '0;
                    res.message_id = n_fbw;
                    case (r_held_header[7:4])
                        TY_PUBLISH: begin
                            res.event_res    = EV_PUBLISH;
                            res.topic_length = n_fbw;
                            tl_plus2         = {13'd0, n_fbw} + 29'd2;
                            if ({1'b0, n_total} >= tl_plus2) begin
                                res.payload_length = n_total - tl_plus2[LEN_W-1:0];
                            end
                        end
                        TY_PUBACK:   res.event_res = EV_PUBACK;
                        TY_PUBREC: begin
                            res.event_res = EV_PUBREC;
                            res.reply     = RP_PUBREL;
                        end
                        TY_PUBCOMP:  res.event_res = EV_PUBCOMP;
                        TY_PINGREQ: begin
                            res.event_res = EV_PINGREQ;
                            res.reply     = RP_PINGRESP;
                        end
                        TY_PINGRESP: res.event_res = EV_PINGRESP;
                        TY_SUBACK:   res.event_res = EV_SUBACK;
                        TY_UNSUBACK: res.event_res = EV_UNSUBACK;
                        default:     res.event_res = EV_OTHER;
                    endcase
                end
            end
        end

        if (!i_accept) begin
            o_push = 1'b0;
        end
        o_result = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keepalive   <= KEEPALIVE_RESET;
            r_phase       <= PH_HEADER;
            r_held_header <= '0;
            r_total       <= '0;
            r_digits      <= '0;
            r_body_left   <= '0;
            r_stored      <= '0;
            r_fbw         <= '0;
            r_overrun     <= 1'b0;
            r_idle        <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_keepalive <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_phase       <= n_phase;
                r_held_header <= n_held_header;
                r_total       <= n_total;
                r_digits      <= n_digits;
                r_body_left   <= n_body_left;
                r_stored      <= n_stored;
                r_fbw         <= n_fbw;
                r_overrun     <= n_overrun;
                r_idle        <= n_idle;
            end
        end
    end

endmodule

`default_nettype wire

/* src/mqip_out_queue.sv */
// Two-entry result queue that decouples the parser from the receiver.
// Depends on mqip_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mqip_out_queue (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_push,
    input  mqip_pkg::t_result  i_data,
    output logic               o_full,
    output logic               o_valid,
    input  wire                i_ready,
    output mqip_pkg::t_result  o_data
);
    import mqip_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_result    r_e0, n_e0;
    t_result    r_e1, n_e1;
    logic       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_e0;

    always_comb begin
        n_e0  = r_e0;
        n_e1  = r_e1;
        n_cnt = r_cnt + {1'b0, i_push} - {1'b0, pop};
        if (pop) begin
            n_e0 = (r_cnt == 2'd2) ? r_e1 : i_data;
            if (r_cnt == 2'd2 && i_push) begin
                n_e1 = i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                n_e0 = i_data;
            end else begin
                n_e1 = i_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e0 <= n_e0;
        r_e1 <= n_e1;
    end

endmodule

`default_nettype wire

/* sim/tb_mqtt_inbound_packet_parser_core.sv */
// Self-checking testbench for the inbound MQTT packet parser core.
// Depends on mqip_pkg and mqtt_inbound_packet_parser_core; byte and tick transactions are
// predicted in the bench and each result is compared field by field as it leaves the block.
`timescale 1ns / 1ps

module tb_mqtt_inbound_packet_parser_core;
    import mqip_pkg::*;

    localparam int MAX_BYTES      = 1024;
    localparam int HALF_PERIOD    = 6;
    localparam int SETTLE_CYCLES  = 6;
    localparam int TIMEOUT_CYCLES = 2000000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 30;

    typedef struct packed {
        logic       mode;
        logic [7:0] data;
    } link_item_t;

    typedef struct packed {
        logic [1:0]       phase;
        logic [7:0]       header;
        logic [LEN_W-1:0] total;
        logic [2:0]       digits;
        logic [LEN_W-1:0] body_left;
        logic [LEN_W-1:0] stored;
        logic [15:0]      first_word;
        logic             overrun;
        logic [KA_W-1:0]  idle_ms;
        logic [KA_W-1:0]  keepalive;
    } parser_state_t;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [KA_W-1:0]  cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    logic             mode        = 1'b0;
    logic [7:0]       rx_byte     = 8'h00;
    logic             out_ready   = 1'b0;
    logic             in_ready;
    logic             out_valid;
    logic [3:0]       event_res;
    logic [7:0]       header_byte;
    logic [15:0]      message_id;
    logic [15:0]      topic_length;
    logic [LEN_W-1:0] payload_length;
    logic [1:0]       reply;

    link_item_t    link_queue[$];
    t_result       awaited_results[$];
    parser_state_t model_st;
    parser_state_t gen_st;

    int  tx_gap         = 0;
    int  rx_stall       = 0;
    bit  tx_idle_en     = 1'b1;
    bit  rx_idle_en     = 1'b1;
    int  cur_keepalive  = KEEPALIVE_RESET;
    int  gen_items      = 0;
    int  items_accepted = 0;
    int  results_seen   = 0;
    int  fail_count     = 0;
    int  settings_used  = 1;
    int  event_tally [16];
    int  ka_plan [0:RANDOM_PHASES-1] = '{255000, 2, 131071, 1, 6, 40, 17, 3};

    mqtt_inbound_packet_parser_core #(
        .MAX_PACKET_BYTES(MAX_BYTES)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_mode           (mode),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_event_res      (event_res),
        .o_header_byte    (header_byte),
        .o_message_id     (message_id),
        .o_topic_length   (topic_length),
        .o_payload_length (payload_length),
        .o_reply          (reply)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Parser behavior for one byte or tick; returns the packet or keepalive report it causes.
    task automatic advance_parser(inout parser_state_t st, input logic is_tick,
                                  input logic [7:0] b, output logic fired,
                                  output t_result res);
        logic [KA_W:0]    idle_next;
        logic [1:0]       k;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] topic_need;
        logic             counted;
        logic             closing;
        fired   = 1'b0;
        res     = '0;
        closing = 1'b0;
        counted = !is_tick && (st.phase == PH_LENGTH || st.phase == PH_BODY);
        if (is_tick) begin
            idle_next = {1'b0, st.idle_ms} + 1'b1;
            if (idle_next > {1'b0, st.keepalive}) begin
                st.idle_ms    = '0;
                fired         = 1'b1;
                res.event_res = EV_KEEPALIVE;
                res.reply     = RP_PINGREQ;
            end else begin
                st.idle_ms = idle_next[KA_W-1:0];
            end
        end else if (st.phase == PH_LENGTH) begin
            k         = st.digits[1:0];
            st.total  = st.total + ({21'd0, b[6:0]} << (7 * k));
            st.digits = {1'b0, k} + 3'd1;
            // The fourth digit closes the field regardless of its continuation bit.
            if (!(b[7] && st.digits < 3'd4)) begin
                if (st.total == '0) begin
                    closing = 1'b1;
                end else begin
                    st.body_left = st.total;
                    st.phase     = PH_BODY;
                end
            end
        end else if (st.phase == PH_BODY) begin
            pos = st.total - st.body_left;
            if (pos == '0)
                st.first_word = {b, 8'h00};
            else if (pos == 1)
                st.first_word = {st.first_word[15:8], b};
            st.body_left = st.body_left - 1'b1;
            if (st.body_left == '0)
                closing = 1'b1;
        end else begin
            st.header     = b;
            st.total      = '0;
            st.digits     = '0;
            st.body_left  = '0;
            st.stored     = 1;
            st.first_word = '0;
            st.overrun    = 1'b0;
            st.phase      = PH_LENGTH;
        end

        if (counted) begin
            if (st.stored < MAX_BYTES)
                st.stored = st.stored + 1'b1;
            else
                st.overrun = 1'b1;
        end

        if (closing) begin
            st.phase        = PH_HEADER;
            fired           = 1'b1;
            res.header_byte = st.header;
            if (st.overrun) begin
                res.event_res = EV_DROPPED;
            end else begin
                res.message_id = st.first_word;
                case (st.header[7:4])
                    TY_PUBLISH: begin
                        res.event_res      = EV_PUBLISH;
                        res.topic_length   = st.first_word;
                        topic_need         = {12'd0, st.first_word} + 28'd2;
                        res.payload_length = (st.total >= topic_need) ? st.total - topic_need
                                                                      : '0;
                    end
                    TY_PUBACK:   res.event_res = EV_PUBACK;
                    TY_PUBREC: begin
                        res.event_res = EV_PUBREC;
                        res.reply     = RP_PUBREL;
                    end
                    TY_PUBCOMP:  res.event_res = EV_PUBCOMP;
                    TY_PINGREQ: begin
                        res.event_res = EV_PINGREQ;
                        res.reply     = RP_PINGRESP;
                    end
                    TY_PINGRESP: res.event_res = EV_PINGRESP;
                    TY_SUBACK:   res.event_res = EV_SUBACK;
                    TY_UNSUBACK: res.event_res = EV_UNSUBACK;
                    default:     res.event_res = EV_OTHER;
                endcase
                st.idle_ms = '0;
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic note_failure(input string why, input t_result want, input t_result got);
        fail_count++;
        if (fail_count <= 10)
            $display({"MISMATCH (%s) at %0t: expected ev=%0d hdr=%02h id=%04h tl=%0d pl=%0d ",
                      "rp=%0d, got ev=%0d hdr=%02h id=%04h tl=%0d pl=%0d rp=%0d"},
                     why, $realtime, want.event_res, want.header_byte, want.message_id,
                     want.topic_length, want.payload_length, want.reply, got.event_res,
                     got.header_byte, got.message_id, got.topic_length, got.payload_length,
                     got.reply);
    endtask

    // Sender: presents queued transactions, with random gaps when tx_idle_en is set.
    always @(posedge i_clk) begin : link_driver
        link_item_t nxt;
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_ready) begin
            if (tx_gap > 0) begin
                in_valid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (link_queue.size() != 0) begin
                nxt      = link_queue.pop_front();
                in_valid <= 1'b1;
                mode     <= nxt.mode;
                rx_byte  <= nxt.data;
                tx_gap   <= tx_idle_en ? pick_gap() : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : report_sink
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else if (rx_stall > 0) begin
            out_ready <= 1'b0;
            rx_stall  <= rx_stall - 1;
        end else if (rx_idle_en && $urandom_range(0, 99) < 20) begin
            out_ready <= 1'b0;
            rx_stall  <= pick_gap();
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : report_checker
        t_result got;
        t_result want;
        t_result predicted;
        logic    fired;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                got.event_res      = event_res;
                got.header_byte    = header_byte;
                got.message_id     = message_id;
                got.topic_length   = topic_length;
                got.payload_length = payload_length;
                got.reply          = reply;
                results_seen++;
                event_tally[event_res]++;
                if (awaited_results.size() == 0) begin
                    note_failure("no report pending", '0, got);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.event_res !== want.event_res || got.header_byte !== want.header_byte
                        || got.message_id !== want.message_id
                        || got.topic_length !== want.topic_length
                        || got.payload_length !== want.payload_length
                        || got.reply !== want.reply)
                        note_failure("field differs", want, got);
                end
            end
            if (in_valid && in_ready) begin
                advance_parser(model_st, mode, rx_byte, fired, predicted);
                items_accepted++;
                if (fired)
                    awaited_results.push_back(predicted);
            end
        end
    end

    // The generator keeps its own copy of the parser so that noise never opens a huge body.
    task automatic push_item(input logic is_tick, input logic [7:0] b);
        logic    fired;
        t_result unused;
        link_queue.push_back({is_tick, b});
        advance_parser(gen_st, is_tick, b, fired, unused);
        gen_items++;
    endtask

    task automatic send_packet(input logic [7:0] hdr, input int len, input bit padded,
                               input int lead_word);
        logic [7:0]  digits[$];
        logic [7:0]  d;
        logic [15:0] word;
        int          rest;
        push_item(1'b0, hdr);
        rest = len;
        for (int n = 0; n == 0 || rest != 0; n++) begin
            d    = rest % 128;
            rest = rest / 128;
            digits.push_back({rest != 0, d[6:0]});
        end
        if (padded && digits.size() < 4) begin
            for (int n = $urandom_range(1, 4 - digits.size()); n > 0; n--) begin
                d = digits.pop_back();
                digits.push_back(d | 8'h80);
                digits.push_back(8'h00);
            end
        end
        foreach (digits[i])
            push_item(1'b0, digits[i]);
        word = lead_word;
        for (int i = 0; i < len; i++) begin
            if (lead_word >= 0 && i == 0)
                push_item(1'b0, word[15:8]);
            else if (lead_word >= 0 && i == 1)
                push_item(1'b0, word[7:0]);
            else
                push_item(1'b0, $urandom_range(0, 255));
        end
    endtask

    task automatic tick_burst(input int n);
        for (int i = 0; i < n; i++)
            push_item(1'b1, $urandom_range(0, 255));
    endtask

    // Stray bytes, then filler until the parser is back at a header boundary.
    task automatic noise_run(input int n);
        for (int i = 0; i < n; i++) begin
            if (gen_st.phase == PH_LENGTH && gen_st.digits != 0)
                push_item(1'b0, {1'($urandom_range(0, 1)), 7'd0});
            else
                push_item(1'b0, $urandom_range(0, 255));
        end
        while (gen_st.phase == PH_LENGTH || gen_st.phase == PH_BODY) begin
            if (gen_st.phase == PH_LENGTH)
                push_item(1'b0, 8'h00);
            else
                push_item(1'b0, $urandom_range(0, 255));
        end
    endtask

    task automatic random_packet(input bit oversized);
        logic [3:0] kind;
        logic [3:0] flags;
        int         r;
        int         len;
        int         lead;
        flags = $urandom_range(0, 15);
        case ($urandom_range(0, 9))
            0:       kind = TY_PUBACK;
            1:       kind = TY_PUBREC;
            2:       kind = TY_PUBCOMP;
            3:       kind = TY_SUBACK;
            4:       kind = TY_UNSUBACK;
            5:       kind = TY_PINGREQ;
            6:       kind = TY_PINGRESP;
            7, 8:    kind = TY_PUBLISH;
            default: kind = $urandom_range(0, 15);
        endcase
        r = $urandom_range(0, 99);
        if (oversized)
            len = $urandom_range(MAX_BYTES - 5, MAX_BYTES);
        else if (r < 70)
            len = $urandom_range(0, 12);
        else if (r < 90)
            len = $urandom_range(13, 40);
        else
            len = $urandom_range(120, 135);
        if (kind == TY_PUBLISH)
            lead = ($urandom_range(0, 9) < 6) ? $urandom_range(0, len) : $urandom_range(0, 65535);
        else
            lead = -1;
        send_packet({kind, flags}, len, !oversized && $urandom_range(0, 9) == 0, lead);
    endtask

    task automatic settle();
        while (link_queue.size() != 0 || in_valid || awaited_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_keepalive(input int value);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= KA_W'(value);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        model_st.keepalive = KA_W'(value);
        cur_keepalive      = value;
        settings_used++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int start;
        int r;
        model_st           = '0;
        model_st.keepalive = KEEPALIVE_RESET;
        gen_st             = model_st;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Each decoded packet type at the reset keepalive, with the replies they call for.
        send_packet(8'hC0, 0, 1'b0, -1);
        send_packet(8'hD0, 0, 1'b0, -1);
        send_packet(8'h40, 2, 1'b0, 16'h1234);
        send_packet(8'h5F, 2, 1'b0, 16'hFFFF);
        send_packet(8'h70, 2, 1'b0, 0);
        send_packet(8'h90, 3, 1'b0, 16'h00A5);
        send_packet(8'hB0, 2, 1'b0, 16'h5A00);
        send_packet(8'h30, 10, 1'b0, 3);
        send_packet(8'h3F, 1, 1'b0, 16'hAB00);
        send_packet(8'h32, 4, 1'b0, 16'hFFFF);
        send_packet(8'h31, 2, 1'b0, 0);
        send_packet(8'h30, 0, 1'b0, -1);
        send_packet(8'h00, 1, 1'b0, -1);
        send_packet(8'hF0, 2, 1'b0, -1);
        send_packet(8'h1A, 3, 1'b0, -1);
        send_packet(8'h65, 2, 1'b0, -1);
        send_packet(8'hE0, 0, 1'b0, -1);
        send_packet(8'hFF, 0, 1'b0, -1);
        // Four length digits all flagged for continuation: the fourth one ends the field.
        push_item(1'b0, 8'hC0);
        repeat (4) push_item(1'b0, 8'h80);
        push_item(1'b0, 8'h3C);
        push_item(1'b0, 8'h81);
        repeat (3) push_item(1'b0, 8'h80);
        push_item(1'b0, 8'h7E);
        send_packet(8'h40, 2, 1'b1, -1);
        send_packet(8'h30, 127, 1'b0, 16'h0010);
        send_packet(8'h30, 128, 1'b0, 16'h0000);
        tick_burst(3);
        settle();

        // Keepalive of 1 ms: every finished packet clears the idle count.
        write_keepalive(1);
        tick_burst(5);
        send_packet(8'hC0, 0, 1'b0, -1);
        tick_burst(2);
        send_packet(8'h30, 6, 1'b0, 0);
        tick_burst(1);
        send_packet(8'hB2, 2, 1'b0, 16'h0101);
        tick_burst(2);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_keepalive((p == 6) ? $urandom_range(7, 255000) : ka_plan[p]);
            tx_idle_en = (p % 3 != 2);
            rx_idle_en = (p % 3 != 2);
            start = gen_items;
            while (gen_items - start < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    random_packet(1'b0);
                else if (r < 85)
                    tick_burst((cur_keepalive <= 64) ? $urandom_range(1, cur_keepalive + 3)
                                                     : $urandom_range(1, 6));
                else
                    noise_run($urandom_range(1, 4));
            end
            // The sender holds off here until every report of the phase is back.
            settle();
        end

        if (awaited_results.size() != 0) begin
            fail_count += awaited_results.size();
            $display("%0d reports never arrived", awaited_results.size());
        end
        $display("Checked %0d reports from %0d byte and tick transactions under %0d %s",
                 results_seen, items_accepted, settings_used, "keepalive settings.");
        $display("Reports: publish %0d, pingreq %0d, pubrec %0d, other %0d, keepalive %0d.",
                 event_tally[EV_PUBLISH], event_tally[EV_PINGREQ], event_tally[EV_PUBREC],
                 event_tally[EV_OTHER], event_tally[EV_KEEPALIVE]);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("Timed out waiting for the parser");
        $display("Verification failed");
        $finish;
    end

endmodule

/* mqtt_inbound_packet_parser_core.f */
+incdir+src
src/mqip_pkg.sv
src/mqip_parser.sv
src/mqip_out_queue.sv
src/mqtt_inbound_packet_parser_core.sv
sim/tb_mqtt_inbound_packet_parser_core.sv
